// ----- rtl/jts_pkg.sv -----
// jts_pkg: token record, per-beat token bundle, token kind and error codes
// shared by the JSON token scanner front end, queue, back end and top level.
// No dependencies.
package jts_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int MAX_TOKENS        = 3;

	localparam logic [3:0] K_LBRACE   = 4'd0;
	localparam logic [3:0] K_RBRACE   = 4'd1;
	localparam logic [3:0] K_LBRACKET = 4'd2;
	localparam logic [3:0] K_RBRACKET = 4'd3;
	localparam logic [3:0] K_COLON    = 4'd4;
	localparam logic [3:0] K_COMMA    = 4'd5;
	localparam logic [3:0] K_TRUE     = 4'd6;
	localparam logic [3:0] K_FALSE    = 4'd7;
	localparam logic [3:0] K_NULL     = 4'd8;
	localparam logic [3:0] K_STRING   = 4'd9;
	localparam logic [3:0] K_NUMBER   = 4'd10;
	localparam logic [3:0] K_END      = 4'd11;
	localparam logic [3:0] K_ERROR    = 4'd12;

	localparam logic [1:0] E_NONE        = 2'd0;
	localparam logic [1:0] E_BAD_LITERAL = 2'd1;
	localparam logic [1:0] E_UNTERM      = 2'd2;
	localparam logic [1:0] E_UNEXPECTED  = 2'd3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  code;
		logic [31:0] start;
		logic [31:0] len;
		logic        frac;
	} token_t;

	// all tokens caused by one input beat, in emission order
	typedef struct packed {
		token_t [MAX_TOKENS-1:0] tok;
		logic   [1:0]            count;
	} bundle_t;

	// append a token; anything past the third is dropped
	function automatic bundle_t push_tok(input bundle_t b, input token_t t);
		bundle_t r;
		r = b;
		if (b.count != 2'd3) begin
			r.tok[b.count] = t;
			r.count = b.count + 2'd1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/jts_front.sv -----
// jts_front: accepts source beats, runs the lexer mode machine and offset
// counter, and builds the bundle of tokens each beat causes.
// Depends on jts_pkg.
module jts_front #(
	parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_ready,
	input  logic [7:0]       data_byte,
	input  logic             has_byte,
	input  logic             is_last,
	input  logic             q_full,
	output logic             q_push,
	output jts_pkg::bundle_t q_data
);
	import jts_pkg::*;

	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_LIT  = 4'd1;
	localparam logic [3:0] M_STR  = 4'd2;
	localparam logic [3:0] M_ESC  = 4'd3;
	localparam logic [3:0] M_HEX  = 4'd4;
	localparam logic [3:0] M_NUM  = 4'd5;
	localparam logic [3:0] M_DOT  = 4'd6;
	localparam logic [3:0] M_FRAC = 4'd7;
	localparam logic [3:0] M_ERR  = 4'd8;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic pos_t span(input pos_t from_p, input pos_t to_p);
		return (to_p > from_p) ? to_p - from_p : '0;
	endfunction

	function automatic token_t mk_tok(input logic [3:0] k_i, input logic [1:0] c_i,
		input pos_t s_i, input pos_t l_i, input logic f_i);
		token_t t;
		t.kind  = k_i;
		t.code  = c_i;
		t.start = 32'(s_i);
		t.len   = 32'(l_i);
		t.frac  = f_i;
		return t;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		unique case ({k, i})
			{2'd0, 3'd0}: c = "r";
			{2'd0, 3'd1}: c = "u";
			{2'd0, 3'd2}: c = "e";
			{2'd1, 3'd0}: c = "a";
			{2'd1, 3'd1}: c = "l";
			{2'd1, 3'd2}: c = "s";
			{2'd1, 3'd3}: c = "e";
			{2'd2, 3'd0}, {2'd3, 3'd0}: c = "u";
			{2'd2, 3'd1}, {2'd3, 3'd1}: c = "l";
			{2'd2, 3'd2}, {2'd3, 3'd2}: c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		return (k == 2'd1) ? 3'd4 : 3'd3;
	endfunction

	function automatic logic [3:0] lit_kind(input logic [1:0] k);
		logic [3:0] r;
		unique case (k)
			2'd0:    r = K_TRUE;
			2'd1:    r = K_FALSE;
			default: r = K_NULL;
		endcase
		return r;
	endfunction

	logic [3:0] mode_q, mode_p, mode_d;
	logic [1:0] lit_kind_q, lit_kind_p, lit_kind_d;
	logic [2:0] lit_idx_q, lit_idx_p, lit_idx_d, lit_idx_inc;
	logic [2:0] hex_q, hex_p, hex_d;
	pos_t       offset_q, offset_p, offset_d;
	pos_t       start_q, start_p, start_d;
	logic       frac_q, frac_p, frac_d;

	pos_t    pos, nxt, dot_p, dot_f;
	logic    run_idle, is_digit, take;
	bundle_t bnd_p, bnd_d;

	assign take      = src_valid & src_ready;
	assign src_ready = !q_full;
	assign q_push    = take && (bnd_d.count != 2'd0);
	assign q_data    = bnd_d;

	assign pos         = offset_q;
	assign nxt         = (offset_q == POS_MAX) ? offset_q : offset_q + POS_ONE;
	assign is_digit    = (data_byte >= "0") && (data_byte <= "9");
	assign lit_idx_inc = lit_idx_q + 3'd1;
	// position of a held dot; a dot before the number start collapses onto it
	assign dot_p       = (pos > start_q) ? pos - POS_ONE : start_q;
	assign dot_f       = (offset_p > start_p) ? offset_p - POS_ONE : start_p;

	// byte step
	always_comb begin
		mode_p     = mode_q;
		lit_kind_p = lit_kind_q;
		lit_idx_p  = lit_idx_q;
		hex_p      = hex_q;
		offset_p   = offset_q;
		start_p    = start_q;
		frac_p     = frac_q;
		bnd_p      = '0;
		run_idle   = 1'b0;
		if (has_byte) begin
			unique case (mode_q)
				M_IDLE: run_idle = 1'b1;
				M_LIT: begin
					if (lit_idx_q < lit_len(lit_kind_q) &&
						lit_char(lit_kind_q, lit_idx_q) == data_byte) begin
						lit_idx_p = lit_idx_inc;
						if (lit_idx_inc >= lit_len(lit_kind_q)) begin
							bnd_p  = push_tok(bnd_p, mk_tok(lit_kind(lit_kind_q), E_NONE,
								start_q, span(start_q, nxt), 1'b0));
							mode_p = M_IDLE;
						end
					end else begin
						bnd_p  = push_tok(bnd_p, mk_tok(K_ERROR, E_BAD_LITERAL,
							start_q, span(start_q, nxt), 1'b0));
						mode_p = M_ERR;
					end
				end
				M_STR: begin
					if (data_byte == "\"") begin
						bnd_p  = push_tok(bnd_p, mk_tok(K_STRING, E_NONE,
							start_q, span(start_q, nxt), 1'b0));
						mode_p = M_IDLE;
					end else if (data_byte == "\\") begin
						mode_p = M_ESC;
					end
				end
				M_ESC: begin
					if (data_byte == "u") begin
						hex_p  = 3'd4;
						mode_p = M_HEX;
					end else begin
						mode_p = M_STR;
					end
				end
				M_HEX: begin
					hex_p = hex_q - 3'd1;
					if (hex_q == 3'd1)
						mode_p = M_STR;
				end
				M_NUM, M_FRAC: begin
					if (is_digit) begin
						mode_p = mode_q;
					end else if (data_byte == "." && mode_q == M_NUM) begin
						mode_p = M_DOT;
					end else begin
						bnd_p    = push_tok(bnd_p, mk_tok(K_NUMBER, E_NONE,
							start_q, span(start_q, pos), frac_q));
						mode_p   = M_IDLE;
						run_idle = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit) begin
						frac_p = 1'b1;
						mode_p = M_FRAC;
					end else begin
						bnd_p  = push_tok(bnd_p, mk_tok(K_NUMBER, E_NONE,
							start_q, span(start_q, dot_p), frac_q));
						bnd_p  = push_tok(bnd_p, mk_tok(K_ERROR, E_UNEXPECTED,
							dot_p, POS_ONE, 1'b0));
						mode_p = M_ERR;
					end
				end
				default: mode_p = mode_q;
			endcase

			if (run_idle) begin
				unique case (data_byte) inside
					"{": bnd_p = push_tok(bnd_p, mk_tok(K_LBRACE, E_NONE, pos, POS_ONE, 1'b0));
					"}": bnd_p = push_tok(bnd_p, mk_tok(K_RBRACE, E_NONE, pos, POS_ONE, 1'b0));
					"[": bnd_p = push_tok(bnd_p, mk_tok(K_LBRACKET, E_NONE, pos, POS_ONE, 1'b0));
					"]": bnd_p = push_tok(bnd_p, mk_tok(K_RBRACKET, E_NONE, pos, POS_ONE, 1'b0));
					":": bnd_p = push_tok(bnd_p, mk_tok(K_COLON, E_NONE, pos, POS_ONE, 1'b0));
					",": bnd_p = push_tok(bnd_p, mk_tok(K_COMMA, E_NONE, pos, POS_ONE, 1'b0));
					8'h20, 8'h0A, 8'h09, 8'h0D: mode_p = M_IDLE;
					"t", "f", "n": begin
						lit_kind_p = (data_byte == "t") ? 2'd0 :
							(data_byte == "f") ? 2'd1 : 2'd2;
						lit_idx_p  = 3'd0;
						start_p    = pos;
						mode_p     = M_LIT;
					end
					"\"": begin
						start_p = pos;
						mode_p  = M_STR;
					end
					["0":"9"], "-": begin
						start_p = pos;
						frac_p  = 1'b0;
						mode_p  = M_NUM;
					end
					default: begin
						bnd_p  = push_tok(bnd_p, mk_tok(K_ERROR, E_UNEXPECTED,
							pos, POS_ONE, 1'b0));
						mode_p = M_ERR;
					end
				endcase
			end
			offset_p = nxt;
		end
	end

	// end of source: close pending token, add the end token, clear state
	always_comb begin
		mode_d     = mode_p;
		lit_kind_d = lit_kind_p;
		lit_idx_d  = lit_idx_p;
		hex_d      = hex_p;
		offset_d   = offset_p;
		start_d    = start_p;
		frac_d     = frac_p;
		bnd_d      = bnd_p;
		if (is_last) begin
			unique case (mode_p)
				M_LIT: bnd_d = push_tok(bnd_d, mk_tok(K_ERROR, E_BAD_LITERAL,
					start_p, span(start_p, offset_p), 1'b0));
				M_STR, M_ESC, M_HEX: bnd_d = push_tok(bnd_d, mk_tok(K_ERROR, E_UNTERM,
					start_p, span(start_p, offset_p), 1'b0));
				M_NUM, M_FRAC: bnd_d = push_tok(bnd_d, mk_tok(K_NUMBER, E_NONE,
					start_p, span(start_p, offset_p), frac_p));
				M_DOT: begin
					bnd_d = push_tok(bnd_d, mk_tok(K_NUMBER, E_NONE,
						start_p, span(start_p, dot_f), frac_p));
					bnd_d = push_tok(bnd_d, mk_tok(K_ERROR, E_UNEXPECTED,
						dot_f, POS_ONE, 1'b0));
				end
				default: bnd_d = bnd_p;
			endcase
			bnd_d      = push_tok(bnd_d, mk_tok(K_END, E_NONE, offset_p, POS_ZERO, 1'b0));
			mode_d     = M_IDLE;
			lit_kind_d = 2'd0;
			lit_idx_d  = 3'd0;
			hex_d      = 3'd0;
			offset_d   = '0;
			start_d    = '0;
			frac_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			lit_kind_q <= 2'd0;
			lit_idx_q  <= 3'd0;
			hex_q      <= 3'd0;
			offset_q   <= '0;
			start_q    <= '0;
			frac_q     <= 1'b0;
		end else if (take) begin
			mode_q     <= mode_d;
			lit_kind_q <= lit_kind_d;
			lit_idx_q  <= lit_idx_d;
			hex_q      <= hex_d;
			offset_q   <= offset_d;
			start_q    <= start_d;
			frac_q     <= frac_d;
		end
	end

endmodule

// ----- rtl/jts_queue.sv -----
// jts_queue: small register FIFO of token bundles between front and back end.
// Depends on jts_pkg.
module jts_queue #(
	parameter int DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jts_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output jts_pkg::bundle_t head,
	output logic             empty
);
	import jts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [AW-1:0] PTR_ONE   = AW'(1);
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)
				cnt_q <= cnt_q + CNT_ONE;
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_ONE;
		end
	end

endmodule

// ----- rtl/jts_back.sv -----
// jts_back: walks the head bundle token by token into the output register,
// marks the final token of each bundle, pops the bundle when done.
// Depends on jts_pkg.
module jts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jts_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	output logic             tok_valid,
	input  logic             tok_ready,
	output jts_pkg::token_t  tok,
	output logic             tok_last
);
	import jts_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q, last_q, load, at_end;
	token_t     tok_q;

	assign load   = !empty && (!valid_q || tok_ready);
	assign at_end = (idx_q == head.count - 2'd1);
	assign pop    = load && at_end;

	assign tok_valid = valid_q;
	assign tok       = tok_q;
	assign tok_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.tok[idx_q];
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (tok_ready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ----- rtl/json_token_scanner_top.sv -----
// json_token_scanner_top: streaming JSON lexer, front end + bundle queue +
// token serializer. Depends on jts_pkg, jts_front, jts_queue, jts_back.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  src     | src_valid/src_ready  | data_byte, has_byte, is_last
//  tok     | tok_valid/tok_ready  | token_kind, error_code, token_start,
//          |                      | token_length, has_fraction, last_of_run
//
// One source beat per cycle is taken while the bundle queue has room.
// Each beat yields zero to three tokens; the output sends one token per cycle
// while tok_ready is high. The first token of a beat is registered in a queue
// slot and then in the output register before it shows as valid.
// The queue holds QUEUE_DEPTH beats; when tok_ready stays low it fills and
// src_ready drops. Reset clears the scanner state, offset and queue at once.
module json_token_scanner_top #(
	parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = jts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        tok_valid,
	input  logic        tok_ready,
	output logic [3:0]  token_kind,
	output logic [1:0]  error_code,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic        has_fraction,
	output logic        last_of_run
);
	import jts_pkg::*;

	logic    q_push, q_full, q_pop, q_empty;
	bundle_t q_in, q_head;
	token_t  tok;

	jts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.is_last   (is_last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	jts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	jts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.tok_last  (last_of_run)
	);

	assign token_kind   = tok.kind;
	assign error_code   = tok.code;
	assign token_start  = tok.start;
	assign token_length = tok.len;
	assign has_fraction = tok.frac;

	// error code set exactly on error tokens
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((token_kind == K_ERROR) == (error_code != E_NONE)))
		else $error("error_code does not match token kind");

	// fraction flag only on numbers
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && has_fraction |-> token_kind == K_NUMBER)
		else $error("has_fraction on a non-number token");

	// end token always closes its beat
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == K_END |-> last_of_run)
		else $error("end token not marked last");

	// empty bundles never enter the queue, and no bundle is pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_in.count != 2'd0 && !q_full)
		else $error("bad queue push");

endmodule

// ----- test/tb_json_token_scanner_top.sv -----
// Self-checking testbench for json_token_scanner_top: byte beats in, token beats out,
// each token checked against a local model of the scanner.
// Depends on jts_pkg and the json_token_scanner_top RTL.
`timescale 1ns / 1ps

package jts_tb_pkg;
	import jts_pkg::*;

	typedef enum logic [3:0] {
		SM_IDLE, SM_LITERAL, SM_STRING, SM_ESCAPE, SM_UNICODE,
		SM_NUMBER, SM_DOT, SM_FRACTION, SM_ERROR
	} scan_mode_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} expected_token_t;

	class token_scoreboard;
		scan_mode_t      mode;
		string           lit_tail;
		logic [3:0]      lit_token;
		int              lit_pos;
		logic [2:0]      hex_left;
		logic [31:0]     pos;
		logic [31:0]     tok_begin;
		logic            frac;
		token_t          beat_toks[$];
		expected_token_t expected_q[$];
		int              failures;
		int              checked;
		int              error_toks;

		function new();
			failures = 0;
			checked = 0;
			error_toks = 0;
			restart();
		endfunction

		function void restart();
			mode = SM_IDLE;
			lit_tail = "rue";
			lit_token = K_TRUE;
			lit_pos = 0;
			hex_left = '0;
			pos = '0;
			tok_begin = '0;
			frac = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_tok(logic [3:0] kind, logic [1:0] code, logic [31:0] start,
				logic [31:0] len, logic f);
			token_t t;
			if (beat_toks.size() >= MAX_TOKENS)
				return;
			t.kind = kind;
			t.code = code;
			t.start = start;
			t.len = len;
			t.frac = f;
			beat_toks.push_back(t);
		endfunction

		function logic [31:0] span(logic [31:0] from, logic [31:0] to);
			return (to > from) ? to - from : 32'd0;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function void close_number(logic [31:0] stop);
			add_tok(K_NUMBER, E_NONE, tok_begin, span(tok_begin, stop), frac);
		endfunction

		// number goes out without the dot, the dot itself is the error
		function void held_dot_fails(logic [31:0] dot_end);
			logic [31:0] dot;
			dot = (dot_end > tok_begin) ? dot_end - 32'd1 : tok_begin;
			close_number(dot);
			add_tok(K_ERROR, E_UNEXPECTED, dot, 32'd1, 1'b0);
			mode = SM_ERROR;
		endfunction

		function void start_literal(string tail, logic [3:0] kind, logic [31:0] at);
			lit_tail = tail;
			lit_token = kind;
			lit_pos = 0;
			tok_begin = at;
			mode = SM_LITERAL;
		endfunction

		function void start_token(logic [7:0] b, logic [31:0] at);
			case (b)
				"{": add_tok(K_LBRACE, E_NONE, at, 32'd1, 1'b0);
				"}": add_tok(K_RBRACE, E_NONE, at, 32'd1, 1'b0);
				"[": add_tok(K_LBRACKET, E_NONE, at, 32'd1, 1'b0);
				"]": add_tok(K_RBRACKET, E_NONE, at, 32'd1, 1'b0);
				":": add_tok(K_COLON, E_NONE, at, 32'd1, 1'b0);
				",": add_tok(K_COMMA, E_NONE, at, 32'd1, 1'b0);
				" ", 8'h0a, 8'h09, 8'h0d: ;
				"t": start_literal("rue", K_TRUE, at);
				"f": start_literal("alse", K_FALSE, at);
				"n": start_literal("ull", K_NULL, at);
				"\"": begin
					tok_begin = at;
					mode = SM_STRING;
				end
				default: begin
					if (is_digit(b) || b == "-") begin
						tok_begin = at;
						frac = 1'b0;
						mode = SM_NUMBER;
					end else begin
						add_tok(K_ERROR, E_UNEXPECTED, at, 32'd1, 1'b0);
						mode = SM_ERROR;
					end
				end
			endcase
		endfunction

		function void scan_byte(logic [7:0] b);
			logic [31:0] at;
			logic [31:0] nxt;
			at = pos;
			nxt = (pos == '1) ? pos : pos + 32'd1;
			case (mode)
				SM_IDLE: start_token(b, at);
				SM_LITERAL: begin
					if (lit_pos < lit_tail.len() && lit_tail[lit_pos] == b) begin
						lit_pos++;
						if (lit_pos >= lit_tail.len()) begin
							add_tok(lit_token, E_NONE, tok_begin, span(tok_begin, nxt), 1'b0);
							mode = SM_IDLE;
						end
					end else begin
						add_tok(K_ERROR, E_BAD_LITERAL, tok_begin, span(tok_begin, nxt), 1'b0);
						mode = SM_ERROR;
					end
				end
				SM_STRING: begin
					if (b == "\"") begin
						add_tok(K_STRING, E_NONE, tok_begin, span(tok_begin, nxt), 1'b0);
						mode = SM_IDLE;
					end else if (b == "\\") begin
						mode = SM_ESCAPE;
					end
				end
				SM_ESCAPE: begin
					if (b == "u") begin
						hex_left = 3'd4;
						mode = SM_UNICODE;
					end else begin
						mode = SM_STRING;
					end
				end
				SM_UNICODE: begin
					hex_left = hex_left - 3'd1;
					if (hex_left == 3'd0)
						mode = SM_STRING;
				end
				SM_NUMBER, SM_FRACTION: begin
					if (!is_digit(b)) begin
						if (b == "." && mode == SM_NUMBER) begin
							mode = SM_DOT;
						end else begin
							close_number(at);
							mode = SM_IDLE;
							start_token(b, at);
						end
					end
				end
				SM_DOT: begin
					if (is_digit(b)) begin
						frac = 1'b1;
						mode = SM_FRACTION;
					end else begin
						held_dot_fails(at);
					end
				end
				default: ;
			endcase
			pos = nxt;
		endfunction

		function void close_source();
			case (mode)
				SM_LITERAL: add_tok(K_ERROR, E_BAD_LITERAL, tok_begin, span(tok_begin, pos), 1'b0);
				SM_STRING, SM_ESCAPE, SM_UNICODE:
					add_tok(K_ERROR, E_UNTERM, tok_begin, span(tok_begin, pos), 1'b0);
				SM_NUMBER, SM_FRACTION: close_number(pos);
				SM_DOT: held_dot_fails(pos);
				default: ;
			endcase
			add_tok(K_END, E_NONE, pos, 32'd0, 1'b0);
		endfunction

		// one accepted source beat -> zero to three expected tokens
		function void note_beat(logic [7:0] b, logic has, logic last);
			expected_token_t e;
			beat_toks.delete();
			if (has)
				scan_byte(b);
			if (last) begin
				close_source();
				restart();
			end
			foreach (beat_toks[i]) begin
				e.tok = beat_toks[i];
				e.last = (i == beat_toks.size() - 1);
				expected_q.push_back(e);
			end
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_token(token_t got, logic got_last);
			expected_token_t want;
			bit ok;
			checked++;
			if (got.kind == K_ERROR)
				error_toks++;
			if (expected_q.size() == 0) begin
				$error("token with nothing expected: kind %0d start %0d", got.kind, got.start);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			ok = field_ok("token_kind", want.tok.kind, got.kind);
			ok = field_ok("error_code", want.tok.code, got.code) & ok;
			ok = field_ok("token_start", want.tok.start, got.start) & ok;
			ok = field_ok("token_length", want.tok.len, got.len) & ok;
			ok = field_ok("has_fraction", want.tok.frac, got.frac) & ok;
			ok = field_ok("last_of_run", want.last, got_last) & ok;
			if (!ok)
				failures++;
		endfunction
	endclass

endpackage

module tb_json_token_scanner_top;
	import jts_pkg::*;
	import jts_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_BEATS   = 410;
	localparam int HOLD_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        is_last = 1'b0;
	logic        tok_valid;
	logic        tok_ready = 1'b0;
	logic [3:0]  token_kind;
	logic [1:0]  error_code;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic        has_fraction;
	logic        last_of_run;

	token_scoreboard sb = new();
	logic [7:0]      src_text[$];
	bit              calm = 1'b0;
	bit              hold_req = 1'b0;
	int              beats_sent = 0;
	int              sources_sent = 0;
	int unsigned     cycles = 0;

	json_token_scanner_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.is_last      (is_last),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.error_code   (error_code),
		.token_start  (token_start),
		.token_length (token_length),
		.has_fraction (has_fraction),
		.last_of_run  (last_of_run)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still expected", cycles, sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	// token sink: random stalls, calm stretch, one long hold-off on request
	initial begin
		token_t seen;
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (tok_valid === 1'b1 && tok_ready) begin
				seen.kind = token_kind;
				seen.code = error_code;
				seen.start = token_start;
				seen.len = token_length;
				seen.frac = has_fraction;
				sb.check_token(seen, last_of_run);
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= calm || ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic send_beat(logic [7:0] b, logic h, logic l);
		while (!calm && $urandom_range(99) < 30) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		data_byte <= b;
		has_byte <= h;
		is_last <= l;
		do @(posedge clk); while (!src_ready);
		sb.note_beat(b, h, l);
		if (h || l)
			beats_sent++;
	endtask

	task automatic send_source(bit bare_end);
		for (int i = 0; i < src_text.size(); i++) begin
			if ($urandom_range(99) < 3)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			send_beat(src_text[i], 1'b1, !bare_end && i == src_text.size() - 1);
		end
		if (bare_end || src_text.size() == 0)
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
		sources_sent++;
		src_text.delete();
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			src_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	function automatic void push_space();
		repeat ($urandom_range(3, 1)) begin
			case ($urandom_range(3))
				0: src_text.push_back(8'h20);
				1: src_text.push_back(8'h0a);
				2: src_text.push_back(8'h09);
				default: src_text.push_back(8'h0d);
			endcase
		end
	endfunction

	function automatic void push_digits(int lo, int hi);
		repeat ($urandom_range(hi, lo))
			src_text.push_back(rand_digit());
	endfunction

	function automatic string rand_literal();
		case ($urandom_range(2))
			0: return "true";
			1: return "false";
			default: return "null";
		endcase
	endfunction

	// string body mixes plain bytes, short escapes, \u with any four bytes, odd escapes
	function automatic void push_string();
		string esc;
		logic [7:0] c;
		esc = "btnfr\"\\/";
		src_text.push_back("\"");
		repeat ($urandom_range(5)) begin
			case ($urandom_range(9))
				5: begin
					src_text.push_back("\\");
					src_text.push_back(esc[$urandom_range(esc.len() - 1)]);
				end
				6: begin
					push_text("\\u");
					repeat (4) src_text.push_back(8'($urandom_range(255)));
				end
				7: begin
					src_text.push_back("\\");
					src_text.push_back(8'($urandom_range(255)));
				end
				8: src_text.push_back(8'($urandom_range(255, 128)));
				default: begin
					c = 8'($urandom_range(8'h7e, 8'h20));
					src_text.push_back((c == "\"" || c == "\\") ? "a" : c);
				end
			endcase
		end
		src_text.push_back("\"");
	endfunction

	function automatic void push_number();
		if ($urandom_range(1))
			src_text.push_back("-");
		push_digits(1, 4);
		if ($urandom_range(99) < 40) begin
			src_text.push_back(".");
			push_digits(1, 3);
		end
	endfunction

	function automatic void push_broken();
		string w;
		string follow;
		int cut;
		follow = ",]} x";
		case ($urandom_range(3))
			0: begin
				w = rand_literal();
				cut = $urandom_range(w.len() - 1, 1);
				for (int i = 0; i < cut; i++)
					src_text.push_back(w[i]);
				src_text.push_back(8'($urandom_range(255)));
			end
			1: src_text.push_back("-");
			2: begin
				push_digits(1, 3);
				src_text.push_back(".");
				src_text.push_back(follow[$urandom_range(follow.len() - 1)]);
			end
			default: src_text.push_back(8'($urandom_range(255)));
		endcase
	endfunction

	function automatic void put_token();
		string punct;
		int pick;
		punct = "{}[]:,";
		pick = $urandom_range(99);
		if (pick < 15)
			src_text.push_back(punct[$urandom_range(5)]);
		else if (pick < 27)
			push_text(rand_literal());
		else if (pick < 52)
			push_string();
		else if (pick < 75)
			push_number();
		else if (pick < 85)
			push_space();
		else
			push_broken();
	endfunction

	initial begin
		bit drained_once;
		bit held_once;
		drained_once = 1'b0;
		held_once = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: escaped quote right after the opening quote, fraction, bare end beat
		push_text("[-1.5,\"\\\"\"}");
		send_source(1'b1);
		// lone minus closed by the last byte
		push_text("{null:-");
		send_source(1'b0);
		send_beat(8'ha5, 1'b0, 1'b0);
		// held dot at the end: number, dot error and end in one beat
		push_text("5.");
		send_source(1'b0);
		// string left open inside a \u escape
		push_text("\"");
		src_text.push_back(8'h00);
		push_text("\\u");
		send_source(1'b0);
		src_text.push_back(8'hff);
		send_source(1'b0);
		wait_drained();

		while (beats_sent < NUM_BEATS) begin
			calm = (beats_sent >= 140 && beats_sent < 230);
			if (beats_sent >= 240 && !drained_once) begin
				wait_drained();
				drained_once = 1'b1;
			end
			if (beats_sent >= 300 && !held_once) begin
				hold_req = 1'b1;
				held_once = 1'b1;
			end
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(6, 1))
					src_text.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(8, 1)) begin
					put_token();
					if ($urandom_range(99) < 30)
						push_space();
				end
				if ($urandom_range(99) < 8) begin
					src_text.push_back("\"");
					if ($urandom_range(1))
						push_text("\\u1");
				end
			end
			send_source($urandom_range(99) < 25);
		end

		src_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d source beats in %0d sources; %0d tokens checked, %0d error tokens",
			beats_sent, sources_sent, sb.checked, sb.error_toks);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
